// ----- sv/hst_pkg.sv -----
// Package with shared constants and types for the Hall step tachometer.
`timescale 1ns / 1ps

package hst_pkg;

    localparam int TICK_W          = 16;
    localparam int MIN_W           = 20;
    localparam int RPM_W           = 16;
    localparam int STEP_TOTAL_W    = 24;
    localparam int OUT_DATA_W      = 56;
    localparam int IN_DATA_W       = 8;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;
    localparam int QUEUE_DEPTH     = 2;

    localparam int INTERVAL_WIDTH_DEF = 20;
    localparam int STEP_WIDTH_DEF     = 24;

    localparam logic [RPM_W-1:0]  RPM_NUM          = 16'd60000;
    localparam logic [TICK_W-1:0] TICK_PERIOD_RST  = 16'd30;
    localparam logic [MIN_W-1:0]  MIN_INTERVAL_RST = 20'd200;

    typedef enum logic {
        REG_TICK_PERIOD,
        REG_MIN_INTERVAL
    } t_reg_idx;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_LOAD
    } t_back_state;

endpackage

// ----- sv/hst_front.sv -----
// Front end: takes sensor samples, tracks the interval and classifies each sample.
`timescale 1ns / 1ps

module hst_front #(
    parameter int INTERVAL_WIDTH = hst_pkg::INTERVAL_WIDTH_DEF,
    parameter int EW             = INTERVAL_WIDTH + hst_pkg::TICK_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_level,
    input  logic [hst_pkg::TICK_W-1:0] i_tick_period,
    input  logic [hst_pkg::MIN_W-1:0]  i_min_interval,
    input  logic                     i_full,
    output logic                     o_push,
    output logic                     o_step,
    output logic [EW-1:0]            o_elapsed
);

    hst_pkg::t_front_state r_state, n_state;
    logic                      r_level, n_level;
    logic                      r_prev, n_prev;
    logic                      r_primed, n_primed;
    logic [INTERVAL_WIDTH-1:0] r_ticks, n_ticks;
    logic [EW-1:0]             r_elapsed, n_elapsed;
    logic                      w_step;

    assign w_step    = r_primed && r_prev && !r_level && (r_elapsed > EW'(i_min_interval));
    assign o_step    = w_step;
    assign o_elapsed = r_elapsed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hst_pkg::F_IDLE;
            r_prev   <= 1'b0;
            r_primed <= 1'b0;
            r_ticks  <= '0;
        end else begin
            r_state  <= n_state;
            r_prev   <= n_prev;
            r_primed <= n_primed;
            r_ticks  <= n_ticks;
        end
        r_level   <= n_level;
        r_elapsed <= n_elapsed;
    end

    always_comb begin
        n_state   = r_state;
        n_level   = r_level;
        n_prev    = r_prev;
        n_primed  = r_primed;
        n_ticks   = r_ticks;
        n_elapsed = r_elapsed;
        o_ready   = 1'b0;
        o_push    = 1'b0;
        case (r_state)
            hst_pkg::F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_level = i_level;
                    n_state = hst_pkg::F_MUL;
                end
            end
            hst_pkg::F_MUL: begin
                n_elapsed = EW'(r_ticks) * EW'(i_tick_period);
                n_state   = hst_pkg::F_PUSH;
            end
            hst_pkg::F_PUSH: begin
                if (!i_full) begin
                    o_push   = 1'b1;
                    n_prev   = r_level;
                    n_primed = 1'b1;
                    // The priming sample leaves the interval counter alone.
                    if (r_primed) begin
                        if (w_step) begin
                            n_ticks = '0;
                        end else if (!(&r_ticks)) begin
                            n_ticks = r_ticks + 1'b1;
                        end
                    end
                    n_state = hst_pkg::F_IDLE;
                end
            end
            default: begin
                n_state = hst_pkg::F_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/hst_queue.sv -----
// Short queue of classified samples between the front end and the back end.
`timescale 1ns / 1ps

module hst_queue #(
    parameter int W = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);

    localparam int PTR_W = $clog2(hst_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(hst_pkg::QUEUE_DEPTH + 1);

    logic [W-1:0]     r_mem [hst_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(hst_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ----- sv/hst_back.sv -----
// Back end: step counting, bit-serial speed division, peak tracking and output register.
`timescale 1ns / 1ps

module hst_back #(
    parameter int INTERVAL_WIDTH = hst_pkg::INTERVAL_WIDTH_DEF,
    parameter int STEP_WIDTH     = hst_pkg::STEP_WIDTH_DEF,
    parameter int EW             = INTERVAL_WIDTH + hst_pkg::TICK_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  logic                          i_step,
    input  logic [EW-1:0]                 i_elapsed,
    output logic                          o_pop,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [hst_pkg::OUT_DATA_W-1:0] o_tdata,
    output logic                          o_tuser
);

    localparam int RW    = hst_pkg::RPM_W;
    localparam int CNT_W = $clog2(RW);

    hst_pkg::t_back_state r_state, n_state;
    logic [STEP_WIDTH-1:0] r_step_count, n_step_count;
    logic [RW-1:0]         r_last_rpm, n_last_rpm;
    logic [RW-1:0]         r_max_rpm, n_max_rpm;
    logic [EW-1:0]         r_rem, n_rem;
    logic [EW-1:0]         r_div, n_div;
    logic [RW-1:0]         r_quo, n_quo;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_pulse, n_out_pulse;
    logic [hst_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                  w_can_load;
    logic [EW:0]           w_trial;
    logic [EW:0]           w_diff;
    logic                  w_ge;
    logic [STEP_WIDTH-1:0] w_count_inc;
    logic [RW-1:0]         w_max_new;
    logic [hst_pkg::STEP_TOTAL_W-1:0] w_total_now;
    logic [hst_pkg::STEP_TOTAL_W-1:0] w_total_inc;

    assign w_can_load  = !r_out_valid || i_tready;
    assign w_trial     = {r_rem, r_quo[RW-1]};
    assign w_ge        = (w_trial >= {1'b0, r_div});
    assign w_diff      = w_trial - {1'b0, r_div};
    assign w_count_inc = (&r_step_count) ? r_step_count : r_step_count + 1'b1;
    assign w_max_new   = (r_quo > r_max_rpm) ? r_quo : r_max_rpm;
    assign w_total_now = hst_pkg::STEP_TOTAL_W'(r_step_count);
    assign w_total_inc = hst_pkg::STEP_TOTAL_W'(w_count_inc);

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;
    assign o_tuser  = r_out_pulse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hst_pkg::B_IDLE;
            r_step_count <= '0;
            r_last_rpm   <= '0;
            r_max_rpm    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step_count <= n_step_count;
            r_last_rpm   <= n_last_rpm;
            r_max_rpm    <= n_max_rpm;
            r_out_valid  <= n_out_valid;
        end
        r_rem       <= n_rem;
        r_div       <= n_div;
        r_quo       <= n_quo;
        r_cnt       <= n_cnt;
        r_out_pulse <= n_out_pulse;
        r_out_data  <= n_out_data;
    end

    always_comb begin
        n_state      = r_state;
        n_step_count = r_step_count;
        n_last_rpm   = r_last_rpm;
        n_max_rpm    = r_max_rpm;
        n_rem        = r_rem;
        n_div        = r_div;
        n_quo        = r_quo;
        n_cnt        = r_cnt;
        n_out_pulse  = r_out_pulse;
        n_out_data   = r_out_data;
        n_out_valid  = r_out_valid && !i_tready;
        o_pop        = 1'b0;
        case (r_state)
            hst_pkg::B_IDLE: begin
                if (!i_empty) begin
                    if (i_step) begin
                        o_pop   = 1'b1;
                        n_div   = i_elapsed;
                        n_rem   = '0;
                        n_quo   = hst_pkg::RPM_NUM;
                        n_cnt   = '0;
                        n_state = hst_pkg::B_DIV;
                    end else if (w_can_load) begin
                        o_pop       = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_pulse = 1'b0;
                        n_out_data  = {r_max_rpm, r_last_rpm, w_total_now};
                    end
                end
            end
            hst_pkg::B_DIV: begin
                // Restoring division, one quotient bit per cycle; the dividend
                // shifts out of the top of the quotient register.
                n_rem = w_ge ? w_diff[EW-1:0] : w_trial[EW-1:0];
                n_quo = {r_quo[RW-2:0], w_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(RW - 1)) begin
                    n_state = hst_pkg::B_LOAD;
                end
            end
            hst_pkg::B_LOAD: begin
                if (w_can_load) begin
                    n_step_count = w_count_inc;
                    n_last_rpm   = r_quo;
                    n_max_rpm    = w_max_new;
                    n_out_valid  = 1'b1;
                    n_out_pulse  = 1'b1;
                    n_out_data   = {w_max_new, r_quo, w_total_inc};
                    n_state      = hst_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = hst_pkg::B_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/hall_step_tachometer.sv -----
// Top level of the Hall step tachometer: configuration registers and the three parts.
//
// Usage: one Hall sensor sample per transaction enters on s_axis (tdata bit 0 is
// the level). Every sample yields exactly one result on m_axis: tuser carries the
// step pulse, tdata carries step total, latest speed and peak speed in rpm.
// A falling edge is a step when ticks since the last step times the tick period
// exceeds the minimum interval; the speed is 60000 divided by that product.
// A sample passes the front end's accept, multiply and classify states, the queue
// and the back end, which loads the output register; a step first goes through the
// bit-serial divider for its 16-bit speed. The front end takes a new sample only
// after classifying the last one, and a two-entry queue lets it run ahead while
// the divider works.
// The result sits in an output register; while the receiver holds m_axis_tready
// low the back end stops, the queue fills, and then s_axis_tready stays low.
// Reset (synchronous, active low) clears the counters, the peak, the priming flag
// and restores tick_period_us = 30 and min_interval_us = 200. The first sample
// after reset only primes the stored level.
// APB: tick_period_us at address 0, min_interval_us at address 4.
`timescale 1ns / 1ps

module hall_step_tachometer #(
    parameter int INTERVAL_WIDTH = hst_pkg::INTERVAL_WIDTH_DEF,
    parameter int STEP_WIDTH     = hst_pkg::STEP_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] sensor_level, [7:1] zero
    input  logic [hst_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [23:0] step_total, [39:24] speed_rpm, [55:40] peak_rpm
    output logic [hst_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] step_pulse
    output logic                              m_axis_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hst_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [hst_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [hst_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int EW = INTERVAL_WIDTH + hst_pkg::TICK_W;

    logic [hst_pkg::TICK_W-1:0] r_tick_period;
    logic [hst_pkg::MIN_W-1:0]  r_min_interval;
    logic                       w_wr;
    hst_pkg::t_reg_idx          w_idx;

    logic          w_push, w_full, w_step, w_pop, w_empty;
    logic [EW-1:0] w_elapsed;
    logic [EW:0]   w_q_out;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = hst_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period  <= hst_pkg::TICK_PERIOD_RST;
            r_min_interval <= hst_pkg::MIN_INTERVAL_RST;
        end else if (w_wr) begin
            case (w_idx)
                hst_pkg::REG_TICK_PERIOD:  r_tick_period  <= pwdata[hst_pkg::TICK_W-1:0];
                hst_pkg::REG_MIN_INTERVAL: r_min_interval <= pwdata[hst_pkg::MIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            hst_pkg::REG_TICK_PERIOD:  prdata = hst_pkg::APB_DATA_W'(r_tick_period);
            hst_pkg::REG_MIN_INTERVAL: prdata = hst_pkg::APB_DATA_W'(r_min_interval);
            default:                   prdata = '0;
        endcase
    end

    hst_front #(
        .INTERVAL_WIDTH (INTERVAL_WIDTH),
        .EW             (EW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_level        (s_axis_tdata[0]),
        .i_tick_period  (r_tick_period),
        .i_min_interval (r_min_interval),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_step         (w_step),
        .o_elapsed      (w_elapsed)
    );

    hst_queue #(
        .W (EW + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_step, w_elapsed}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_q_out)
    );

    hst_back #(
        .INTERVAL_WIDTH (INTERVAL_WIDTH),
        .STEP_WIDTH     (STEP_WIDTH),
        .EW             (EW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (w_empty),
        .i_step    (w_q_out[EW]),
        .i_elapsed (w_q_out[EW-1:0]),
        .o_pop     (w_pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tuser   (m_axis_tuser)
    );

    // A reported step always leaves a nonzero step total.
    a_pulse_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[23:0] != '0))
        else $error("step pulse with zero step total");

    // The latest speed never exceeds the peak.
    a_speed_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:24] <= m_axis_tdata[55:40]))
        else $error("speed above peak");

    // The front end is busy for the cycle after taking a sample.
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("sample accepted on consecutive cycles");

    // The queue is never pushed while full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push)
        else $error("queue overflow");

endmodule

// ----- dv/hall_step_tachometer_test.sv -----
// Self-checking testbench for the Hall step tachometer: stream stimulus, APB setup, result checks.
`timescale 1ns / 1ps

module hall_step_tachometer_test;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RAND_PHASES  = 12;
    localparam int STEP_MAX     = (1 << hst_pkg::STEP_TOTAL_W) - 1;
    localparam int INTERVAL_MAX = (1 << hst_pkg::INTERVAL_WIDTH_DEF) - 1;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic                             pulse;
        logic [hst_pkg::STEP_TOTAL_W-1:0] total;
        logic [hst_pkg::RPM_W-1:0]        speed;
        logic [hst_pkg::RPM_W-1:0]        peak;
    } t_reading;

    logic                           i_clk;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // [0] sensor_level, [7:1] zero
    logic [hst_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // [23:0] step_total, [39:24] speed_rpm, [55:40] peak_rpm
    logic [hst_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    // [0] step_pulse
    logic                           m_axis_tuser;
    logic                           psel          = 1'b0;
    logic                           penable       = 1'b0;
    logic                           pwrite        = 1'b0;
    logic [hst_pkg::APB_ADDR_W-1:0] paddr         = '0;
    logic [hst_pkg::APB_DATA_W-1:0] pwdata        = '0;
    logic [hst_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    hall_step_tachometer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Shadow copy of the tachometer state and its two registers.
    logic [hst_pkg::TICK_W-1:0]             tick_cfg   = hst_pkg::TICK_PERIOD_RST;
    logic [hst_pkg::MIN_W-1:0]              min_cfg    = hst_pkg::MIN_INTERVAL_RST;
    logic                                   last_level = 1'b0;
    logic                                   primed     = 1'b0;
    logic [hst_pkg::INTERVAL_WIDTH_DEF-1:0] ticks_cnt  = '0;
    logic [hst_pkg::STEP_TOTAL_W-1:0]       steps_cnt  = '0;
    logic [hst_pkg::RPM_W-1:0]              speed_now  = '0;
    logic [hst_pkg::RPM_W-1:0]              speed_peak = '0;

    bit         pending_levels[$];
    t_reading   expected_readings[$];
    t_idle_mode idle_mode    = IDLE_NONE;
    int         hold_req     = 0;
    int         hold_seen    = 0;
    int         hold_left    = 0;
    int         cycle_count  = 0;
    int         error_count  = 0;
    int         samples_sent = 0;
    int         readings_ok  = 0;
    int         steps_seen   = 0;
    int         settings_cnt = 0;

    function automatic t_reading tach_predict(input logic level);
        t_reading   r;
        logic [47:0] elapsed;
        r.pulse = 1'b0;
        if (!primed) begin
            primed = 1'b1;
        end else begin
            elapsed = 48'(ticks_cnt) * 48'(tick_cfg);
            if (last_level && !level && elapsed > 48'(min_cfg)) begin
                if (steps_cnt != hst_pkg::STEP_TOTAL_W'(STEP_MAX)) begin
                    steps_cnt = steps_cnt + 1'b1;
                end
                speed_now = hst_pkg::RPM_W'(48'(hst_pkg::RPM_NUM) / elapsed);
                if (speed_now > speed_peak) begin
                    speed_peak = speed_now;
                end
                ticks_cnt = '0;
                r.pulse = 1'b1;
            end else if (ticks_cnt != hst_pkg::INTERVAL_WIDTH_DEF'(INTERVAL_MAX)) begin
                ticks_cnt = ticks_cnt + 1'b1;
            end
        end
        last_level = level;
        r.total = steps_cnt;
        r.speed = speed_now;
        r.peak  = speed_peak;
        return r;
    endfunction

    // Sender: presents queued sensor samples and predicts each accepted one.
    always @(posedge i_clk) begin
        bit go;
        bit lvl;
        int pct;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_readings.push_back(tach_predict(s_axis_tdata[0]));
                samples_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                pct = (idle_mode == IDLE_SENDER) ? 57 : (idle_mode == IDLE_BOTH) ? 11 : 0;
                go  = (pending_levels.size() != 0) && ($urandom_range(99) >= pct);
                if (go) begin
                    lvl = pending_levels.pop_front();
                    s_axis_tdata <= {{(hst_pkg::IN_DATA_W-1){1'b0}}, lvl};
                end
                s_axis_tvalid <= go;
            end
        end
    end

    // Long receiver hold-off, counted here so the block fills and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: checks every accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        t_reading want;
        t_reading got;
        int       pct;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.pulse = m_axis_tuser;
                got.total = m_axis_tdata[23:0];
                got.speed = m_axis_tdata[39:24];
                got.peak  = m_axis_tdata[55:40];
                if (got.pulse) begin
                    steps_seen++;
                end
                if (expected_readings.size() == 0) begin
                    $display("%0t: unexpected result transaction, actual pulse %0d total %0d",
                             $realtime, got.pulse, got.total);
                    error_count++;
                end else begin
                    want = expected_readings.pop_front();
                    if (got.pulse !== want.pulse) begin
                        $display("%0t: step_pulse expected %0d actual %0d",
                                 $realtime, want.pulse, got.pulse);
                        error_count++;
                    end
                    if (got.total !== want.total) begin
                        $display("%0t: step_total expected %0d actual %0d",
                                 $realtime, want.total, got.total);
                        error_count++;
                    end
                    if (got.speed !== want.speed) begin
                        $display("%0t: speed_rpm expected %0d actual %0d",
                                 $realtime, want.speed, got.speed);
                        error_count++;
                    end
                    if (got.peak !== want.peak) begin
                        $display("%0t: peak_rpm expected %0d actual %0d",
                                 $realtime, want.peak, got.peak);
                        error_count++;
                    end
                    readings_ok++;
                end
            end
            pct = (idle_mode == IDLE_RECEIVER) ? 57 : (idle_mode == IDLE_BOTH) ? 11 : 0;
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run exceeded the cycle limit with %0d results outstanding.",
                     expected_readings.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(input hst_pkg::t_reg_idx idx,
                             input logic [hst_pkg::APB_DATA_W-1:0] value);
        logic [hst_pkg::APB_DATA_W-1:0] want;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        // The register takes the value at this edge.
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            hst_pkg::REG_TICK_PERIOD: begin
                tick_cfg = value[hst_pkg::TICK_W-1:0];
                want     = hst_pkg::APB_DATA_W'(tick_cfg);
            end
            hst_pkg::REG_MIN_INTERVAL: begin
                min_cfg = value[hst_pkg::MIN_W-1:0];
                want    = hst_pkg::APB_DATA_W'(min_cfg);
            end
            default: want = '0;
        endcase
        // A read transaction right behind the write checks the stored value.
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (!pready || prdata !== want) begin
            $display("%0t: register %0d readback expected %0d actual %0d",
                     $realtime, idx, want, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input int tick, input int min_us, input t_idle_mode mode);
        write_reg(hst_pkg::REG_TICK_PERIOD, hst_pkg::APB_DATA_W'(tick));
        write_reg(hst_pkg::REG_MIN_INTERVAL, hst_pkg::APB_DATA_W'(min_us));
        idle_mode <= mode;
        settings_cnt++;
    endtask

    task automatic queue_run(input bit level, input int count);
        repeat (count) pending_levels.push_back(level);
    endtask

    // Square wave with random run lengths and an occasional one-sample glitch.
    task automatic queue_wave(input int count, input int max_run);
        bit level;
        int run;
        level = $urandom_range(1);
        while (count > 0) begin
            run = ($urandom_range(9) == 0) ? 1 : $urandom_range(max_run, 1);
            if (run > count) begin
                run = count;
            end
            queue_run(level, run);
            count -= run;
            level = !level;
        end
    endtask

    task automatic queue_noise(input int count);
        repeat (count) pending_levels.push_back(bit'($urandom_range(1)));
    endtask

    // Sampled on the falling edge so that the driver's updates have settled.
    task automatic wait_drained();
        while (pending_levels.size() != 0 || s_axis_tvalid || expected_readings.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int tick;
        int min_us;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults: priming sample, then twice a falling edge too soon followed by a real step.
        queue_run(1'b1, 1);
        queue_run(1'b0, 1);
        queue_run(1'b1, 7);
        queue_run(1'b0, 2);
        queue_run(1'b1, 1);
        queue_run(1'b0, 1);
        queue_run(1'b1, 6);
        queue_run(1'b0, 1);
        wait_drained();

        // Zero tick period never yields a step.
        configure(0, 0, IDLE_NONE);
        repeat (6) begin
            queue_run(1'b1, 1);
            queue_run(1'b0, 1);
        end
        wait_drained();

        // Shortest interval gives the top speed.
        configure(1, 0, IDLE_BOTH);
        repeat (5) begin
            queue_run(1'b1, 1);
            queue_run(1'b0, 1);
        end
        wait_drained();

        // Largest period and minimum: a step needs seventeen ticks, speed floors to zero.
        configure(65535, 1048575, IDLE_NONE);
        queue_run(1'b1, 15);
        queue_run(1'b0, 1);
        queue_run(1'b1, 17);
        queue_run(1'b0, 1);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(3))
                0: tick = $urandom_range(40, 1);
                1: tick = $urandom_range(600, 41);
                2: tick = $urandom_range(65535, 1);
                default: tick = 1;
            endcase
            case ($urandom_range(3))
                0: min_us = 0;
                1: min_us = $urandom_range(20 * tick > 1048575 ? 1048575 : 20 * tick);
                2: min_us = $urandom_range(1048575);
                default: min_us = $urandom_range(5 * tick > 1048575 ? 1048575 : 5 * tick);
            endcase
            configure(tick, min_us, t_idle_mode'(ph % 4));
            if (ph == 2) begin
                hold_req <= hold_req + 1;
            end
            queue_wave(130, $urandom_range(40, 2));
            queue_noise(20);
            wait_drained();
        end

        repeat (40) @(posedge i_clk);
        $display("Checked %0d results from %0d samples over %0d register settings.",
                 readings_ok, samples_sent, settings_cnt);
        $display("Saw %0d steps, final speed %0d rpm, peak %0d rpm.",
                 steps_seen, speed_now, speed_peak);
        if (error_count == 0 && expected_readings.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- hall_step_tachometer.f -----
sv/hst_pkg.sv
sv/hst_front.sv
sv/hst_queue.sv
sv/hst_back.sv
sv/hall_step_tachometer.sv
dv/hall_step_tachometer_test.sv
